FILE: src/imu_tc_pkg.sv
// Shared widths, register codes, reset values and the result record for the
// temperature-compensated inertial scaling block. No dependencies.
package imu_tc_pkg;

    localparam int RAW_W     = 16;  // raw sensor and temperature words
    localparam int COEF_W    = 20;  // configuration coefficients
    localparam int OUT_W     = 28;  // Q4.24 results
    localparam int GAIN_W    = 29;  // effective gain, units 2^-40
    localparam int CT_W      = 37;  // coefficient times temperature
    localparam int CT_LO_W   = 18;  // low slice of the gain factor product
    localparam int CT_HI_W   = CT_W - CT_LO_W;
    localparam int SUM_W     = 63;  // base gain times full Q40 factor
    localparam int ONE_SHIFT = 40;  // 1.0 in the Q40 gain factor
    localparam int GAIN_LSB  = 32;  // drop 2^-32 scaling of the base gain
    localparam int PROD_W    = 46;  // raw times effective gain
    localparam int ACC_W     = 47;  // product minus offset term
    localparam int FRAC_DROP = 16;  // units 2^-40 down to Q4.24
    localparam int NUM_AXES  = 6;
    localparam int PIPE_LAT  = 5;   // register stages from accept to result

    typedef enum logic [2:0] {
        REG_GYRO_BASE_GAIN   = 3'd0,
        REG_ACCEL_BASE_GAIN  = 3'd1,
        REG_GYRO_GAIN_TC     = 3'd2,
        REG_ACCEL_GAIN_TC    = 3'd3,
        REG_GYRO_OFFSET_TC   = 3'd4,
        REG_ACCEL_OFFSET_TC  = 3'd5
    } cfg_reg_t;

    localparam logic [COEF_W-1:0] RST_GYRO_BASE_GAIN  = 20'd327956;
    localparam logic [COEF_W-1:0] RST_ACCEL_BASE_GAIN = 20'd261993;
    localparam logic [COEF_W-1:0] RST_GYRO_GAIN_TC    = 20'd300648;
    localparam logic [COEF_W-1:0] RST_ACCEL_GAIN_TC   = 20'd429497;
    localparam logic [COEF_W-1:0] RST_GYRO_OFFSET_TC  = 20'd374806;
    localparam logic [COEF_W-1:0] RST_ACCEL_OFFSET_TC = 20'd429497;

    typedef struct packed {
        logic signed [OUT_W-1:0] gyro_rate_x;
        logic signed [OUT_W-1:0] gyro_rate_y;
        logic signed [OUT_W-1:0] gyro_rate_z;
        logic signed [OUT_W-1:0] accel_g_x;
        logic signed [OUT_W-1:0] accel_g_y;
        logic signed [OUT_W-1:0] accel_g_z;
    } out_item_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

endpackage

FILE: src/imu_tc_gain.sv
// Per-sensor gain path: temperature-corrected gain and offset term, three stages.
// Depends on imu_tc_pkg.
module imu_tc_gain (
    input  logic                                      aclk,
    input  logic signed [imu_tc_pkg::RAW_W-1:0]       temp_in,
    input  logic        [imu_tc_pkg::COEF_W-1:0]      base_gain,
    input  logic        [imu_tc_pkg::COEF_W-1:0]      gain_tc,
    input  logic        [imu_tc_pkg::COEF_W-1:0]      offset_tc,
    output logic        [imu_tc_pkg::GAIN_W-1:0]      gain_out,
    output logic signed [imu_tc_pkg::CT_W-1:0]        offset_out
);

    localparam int LO_PROD_W = imu_tc_pkg::COEF_W + imu_tc_pkg::CT_LO_W;
    localparam int HI_PROD_W = imu_tc_pkg::COEF_W + 1 + imu_tc_pkg::CT_HI_W;

    logic signed [imu_tc_pkg::CT_W-1:0]  ct_reg;
    logic signed [imu_tc_pkg::CT_W-1:0]  ot1_reg;
    logic signed [imu_tc_pkg::CT_W-1:0]  ot2_reg;
    logic signed [imu_tc_pkg::CT_W-1:0]  ot3_reg;
    logic        [LO_PROD_W-1:0]         b_lo_reg;
    logic signed [HI_PROD_W-1:0]         b_hi_reg;
    logic        [imu_tc_pkg::GAIN_W-1:0] gain_reg;
    logic signed [imu_tc_pkg::SUM_W-1:0] sum_full;

    // Factor is 2^40 + c*t; split c*t so each product stays narrow.
    always_comb begin
        sum_full = $signed({3'b000, base_gain, {imu_tc_pkg::ONE_SHIFT{1'b0}}})
                 + $signed({{(imu_tc_pkg::SUM_W - HI_PROD_W - imu_tc_pkg::CT_LO_W)
                              {b_hi_reg[HI_PROD_W-1]}},
                            b_hi_reg, {imu_tc_pkg::CT_LO_W{1'b0}}})
                 + $signed({{(imu_tc_pkg::SUM_W - LO_PROD_W){1'b0}}, b_lo_reg});
    end

    always_ff @(posedge aclk) begin
        ct_reg   <= $signed({1'b0, gain_tc}) * temp_in;
        ot1_reg  <= $signed({1'b0, offset_tc}) * temp_in;
        b_lo_reg <= base_gain * ct_reg[imu_tc_pkg::CT_LO_W-1:0];
        b_hi_reg <= $signed({1'b0, base_gain})
                  * $signed(ct_reg[imu_tc_pkg::CT_W-1:imu_tc_pkg::CT_LO_W]);
        ot2_reg  <= ot1_reg;
        // Product is never negative, so the slice is the floor.
        gain_reg <= sum_full[imu_tc_pkg::GAIN_LSB + imu_tc_pkg::GAIN_W - 1:
                             imu_tc_pkg::GAIN_LSB];
        ot3_reg  <= ot2_reg;
    end

    assign gain_out   = gain_reg;
    assign offset_out = ot3_reg;

endmodule

FILE: src/imu_tc_lane.sv
// One axis lane: raw times gain, bias removal, floor shift and saturation.
// Two register stages. Depends on imu_tc_pkg.
module imu_tc_lane (
    input  logic                                   aclk,
    input  logic signed [imu_tc_pkg::RAW_W-1:0]    raw_in,
    input  logic        [imu_tc_pkg::GAIN_W-1:0]   gain_in,
    input  logic signed [imu_tc_pkg::CT_W-1:0]     offset_in,
    output logic signed [imu_tc_pkg::OUT_W-1:0]    result_out
);

    localparam int Q_W = imu_tc_pkg::ACC_W - imu_tc_pkg::FRAC_DROP;

    logic signed [imu_tc_pkg::PROD_W-1:0] prod_reg;
    logic signed [imu_tc_pkg::CT_W-1:0]   ofs_reg;
    logic signed [imu_tc_pkg::OUT_W-1:0]  result_reg;
    logic signed [imu_tc_pkg::ACC_W-1:0]  acc;
    logic        [Q_W-1:0]                q;
    logic signed [imu_tc_pkg::OUT_W-1:0]  result_next;

    always_comb begin
        acc = $signed({prod_reg[imu_tc_pkg::PROD_W-1], prod_reg})
            - $signed({{(imu_tc_pkg::ACC_W - imu_tc_pkg::CT_W){ofs_reg[imu_tc_pkg::CT_W-1]}},
                       ofs_reg});
        // Arithmetic shift by slicing: floor toward negative infinity.
        q = acc[imu_tc_pkg::ACC_W-1:imu_tc_pkg::FRAC_DROP];
        if (!q[Q_W-1] && (|q[Q_W-1:imu_tc_pkg::OUT_W-1])) begin
            result_next = {1'b0, {(imu_tc_pkg::OUT_W-1){1'b1}}};
        end else if (q[Q_W-1] && !(&q[Q_W-1:imu_tc_pkg::OUT_W-1])) begin
            result_next = {1'b1, {(imu_tc_pkg::OUT_W-1){1'b0}}};
        end else begin
            result_next = $signed(q[imu_tc_pkg::OUT_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= raw_in * $signed({1'b0, gain_in});
        ofs_reg    <= offset_in;
        result_reg <= result_next;
    end

    assign result_out = result_reg;

endmodule

FILE: src/imu_tc_fifo.sv
// Result queue that holds the six merged lane outputs as one transaction.
// Register storage, one read port. Depends on imu_tc_pkg.
module imu_tc_fifo #(
    parameter int DEPTH = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  imu_tc_pkg::fifo_ctrl_t ctrl,
    input  imu_tc_pkg::out_item_t  wr_data,
    output imu_tc_pkg::out_item_t  rd_data,
    output logic                   empty
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    imu_tc_pkg::out_item_t mem_reg [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (ctrl.push) begin
            wr_ptr_next = (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (ctrl.pop) begin
            rd_ptr_next = (rd_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (ctrl.push && !ctrl.pop) begin
            count_next = count_reg + 1'b1;
        end else if (!ctrl.push && ctrl.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign empty   = (count_reg == '0);

endmodule

FILE: src/imu_sample_temp_compensation.sv
// Top level: configuration registers, two gain paths, six axis lanes and the
// result queue. Depends on imu_tc_pkg, imu_tc_gain, imu_tc_lane, imu_tc_fifo.
//
//   channel   ports                        direction  transaction
//   input     s_valid/s_ready, s_*         in         one raw six-axis sample
//   result    m_valid/m_ready, m_*         out        one compensated sample
//   config    cfg_valid/cfg_ready, cfg_*   in         one register write
//
// One sample per clock while credits last; each result passes the three gain
// stages, the lane multiply, the saturate stage and the queue write.
// Reset clears the pipeline valids and the queue and loads default coefficients.
// A credit counter covers samples in flight plus queued results: input stalls
// only once FIFO_DEPTH of them are outstanding. Config writes are always taken.
module imu_sample_temp_compensation #(
    parameter int FIFO_DEPTH = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [imu_tc_pkg::RAW_W-1:0]   s_temp_raw,
    input  logic signed [imu_tc_pkg::RAW_W-1:0]   s_gyro_raw_x,
    input  logic signed [imu_tc_pkg::RAW_W-1:0]   s_gyro_raw_y,
    input  logic signed [imu_tc_pkg::RAW_W-1:0]   s_gyro_raw_z,
    input  logic signed [imu_tc_pkg::RAW_W-1:0]   s_accel_raw_x,
    input  logic signed [imu_tc_pkg::RAW_W-1:0]   s_accel_raw_y,
    input  logic signed [imu_tc_pkg::RAW_W-1:0]   s_accel_raw_z,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [imu_tc_pkg::OUT_W-1:0]   m_gyro_rate_x,
    output logic signed [imu_tc_pkg::OUT_W-1:0]   m_gyro_rate_y,
    output logic signed [imu_tc_pkg::OUT_W-1:0]   m_gyro_rate_z,
    output logic signed [imu_tc_pkg::OUT_W-1:0]   m_accel_g_x,
    output logic signed [imu_tc_pkg::OUT_W-1:0]   m_accel_g_y,
    output logic signed [imu_tc_pkg::OUT_W-1:0]   m_accel_g_z,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [2:0]                            cfg_index,
    input  logic [imu_tc_pkg::COEF_W-1:0]         cfg_data
);

    localparam int OCC_W = $clog2(FIFO_DEPTH + 1);

    logic [imu_tc_pkg::COEF_W-1:0] gyro_base_gain_reg, accel_base_gain_reg;
    logic [imu_tc_pkg::COEF_W-1:0] gyro_gain_tc_reg, accel_gain_tc_reg;
    logic [imu_tc_pkg::COEF_W-1:0] gyro_offset_tc_reg, accel_offset_tc_reg;

    logic s_accept, m_pop;
    logic [imu_tc_pkg::PIPE_LAT-1:0] pipe_valid_reg;
    logic [OCC_W-1:0] occ_reg, occ_next;

    logic signed [imu_tc_pkg::RAW_W-1:0] raw_in [imu_tc_pkg::NUM_AXES];
    logic signed [imu_tc_pkg::RAW_W-1:0] raw_d1_reg [imu_tc_pkg::NUM_AXES];
    logic signed [imu_tc_pkg::RAW_W-1:0] raw_d2_reg [imu_tc_pkg::NUM_AXES];
    logic signed [imu_tc_pkg::RAW_W-1:0] raw_d3_reg [imu_tc_pkg::NUM_AXES];
    logic signed [imu_tc_pkg::OUT_W-1:0] lane_out [imu_tc_pkg::NUM_AXES];

    logic        [imu_tc_pkg::GAIN_W-1:0] gyro_gain, accel_gain;
    logic signed [imu_tc_pkg::CT_W-1:0]   gyro_ofs, accel_ofs;

    imu_tc_pkg::out_item_t  merged_item, head_item;
    imu_tc_pkg::fifo_ctrl_t fifo_ctrl;
    logic fifo_empty;

    // Configuration writes; indexes past the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gyro_base_gain_reg  <= imu_tc_pkg::RST_GYRO_BASE_GAIN;
            accel_base_gain_reg <= imu_tc_pkg::RST_ACCEL_BASE_GAIN;
            gyro_gain_tc_reg    <= imu_tc_pkg::RST_GYRO_GAIN_TC;
            accel_gain_tc_reg   <= imu_tc_pkg::RST_ACCEL_GAIN_TC;
            gyro_offset_tc_reg  <= imu_tc_pkg::RST_GYRO_OFFSET_TC;
            accel_offset_tc_reg <= imu_tc_pkg::RST_ACCEL_OFFSET_TC;
        end else if (cfg_valid && cfg_ready) begin
            unique case (imu_tc_pkg::cfg_reg_t'(cfg_index))
                imu_tc_pkg::REG_GYRO_BASE_GAIN:  gyro_base_gain_reg  <= cfg_data;
                imu_tc_pkg::REG_ACCEL_BASE_GAIN: accel_base_gain_reg <= cfg_data;
                imu_tc_pkg::REG_GYRO_GAIN_TC:    gyro_gain_tc_reg    <= cfg_data;
                imu_tc_pkg::REG_ACCEL_GAIN_TC:   accel_gain_tc_reg   <= cfg_data;
                imu_tc_pkg::REG_GYRO_OFFSET_TC:  gyro_offset_tc_reg  <= cfg_data;
                imu_tc_pkg::REG_ACCEL_OFFSET_TC: accel_offset_tc_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Credits: samples in the pipeline plus results waiting in the queue.
    assign s_ready  = (occ_reg < OCC_W'(FIFO_DEPTH));
    assign s_accept = s_valid && s_ready;
    assign m_valid  = !fifo_empty;
    assign m_pop    = m_valid && m_ready;

    always_comb begin
        occ_next = occ_reg;
        if (s_accept && !m_pop) begin
            occ_next = occ_reg + 1'b1;
        end else if (!s_accept && m_pop) begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg        <= '0;
            pipe_valid_reg <= '0;
        end else begin
            occ_reg        <= occ_next;
            pipe_valid_reg <= {pipe_valid_reg[imu_tc_pkg::PIPE_LAT-2:0], s_accept};
        end
    end

    assign raw_in[0] = s_gyro_raw_x;
    assign raw_in[1] = s_gyro_raw_y;
    assign raw_in[2] = s_gyro_raw_z;
    assign raw_in[3] = s_accel_raw_x;
    assign raw_in[4] = s_accel_raw_y;
    assign raw_in[5] = s_accel_raw_z;

    // Hold raw words until the gain paths catch up.
    always_ff @(posedge aclk) begin
        raw_d1_reg <= raw_in;
        raw_d2_reg <= raw_d1_reg;
        raw_d3_reg <= raw_d2_reg;
    end

    imu_tc_gain u_gyro_gain (
        .aclk       (aclk),
        .temp_in    (s_temp_raw),
        .base_gain  (gyro_base_gain_reg),
        .gain_tc    (gyro_gain_tc_reg),
        .offset_tc  (gyro_offset_tc_reg),
        .gain_out   (gyro_gain),
        .offset_out (gyro_ofs)
    );

    imu_tc_gain u_accel_gain (
        .aclk       (aclk),
        .temp_in    (s_temp_raw),
        .base_gain  (accel_base_gain_reg),
        .gain_tc    (accel_gain_tc_reg),
        .offset_tc  (accel_offset_tc_reg),
        .gain_out   (accel_gain),
        .offset_out (accel_ofs)
    );

    for (genvar i = 0; i < imu_tc_pkg::NUM_AXES; i++) begin : g_lane
        imu_tc_lane u_lane (
            .aclk       (aclk),
            .raw_in     (raw_d3_reg[i]),
            .gain_in    ((i < imu_tc_pkg::NUM_AXES / 2) ? gyro_gain : accel_gain),
            .offset_in  ((i < imu_tc_pkg::NUM_AXES / 2) ? gyro_ofs : accel_ofs),
            .result_out (lane_out[i])
        );
    end

    always_comb begin
        merged_item.gyro_rate_x = lane_out[0];
        merged_item.gyro_rate_y = lane_out[1];
        merged_item.gyro_rate_z = lane_out[2];
        merged_item.accel_g_x   = lane_out[3];
        merged_item.accel_g_y   = lane_out[4];
        merged_item.accel_g_z   = lane_out[5];
        fifo_ctrl.push = pipe_valid_reg[imu_tc_pkg::PIPE_LAT-1];
        fifo_ctrl.pop  = m_pop;
    end

    imu_tc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (fifo_ctrl),
        .wr_data (merged_item),
        .rd_data (head_item),
        .empty   (fifo_empty)
    );

    assign m_gyro_rate_x = head_item.gyro_rate_x;
    assign m_gyro_rate_y = head_item.gyro_rate_y;
    assign m_gyro_rate_z = head_item.gyro_rate_z;
    assign m_accel_g_x   = head_item.accel_g_x;
    assign m_accel_g_y   = head_item.accel_g_y;
    assign m_accel_g_z   = head_item.accel_g_z;

    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(FIFO_DEPTH))
        else $error("credit count exceeds queue depth");

    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##6 m_valid)
        else $error("accepted sample did not reach the result queue");

    a_result_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> occ_reg != '0)
        else $error("result present without an outstanding credit");

endmodule

FILE: tb/sv/imu_sample_temp_compensation_checker.sv
// Result checker for imu_sample_temp_compensation: tracks register writes,
// predicts every compensated sample and compares the result stream in order.
// Depends on imu_tc_pkg.
module imu_sample_temp_compensation_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic signed [imu_tc_pkg::RAW_W-1:0]  s_temp_raw,
    input  logic signed [imu_tc_pkg::RAW_W-1:0]  s_gyro_raw_x,
    input  logic signed [imu_tc_pkg::RAW_W-1:0]  s_gyro_raw_y,
    input  logic signed [imu_tc_pkg::RAW_W-1:0]  s_gyro_raw_z,
    input  logic signed [imu_tc_pkg::RAW_W-1:0]  s_accel_raw_x,
    input  logic signed [imu_tc_pkg::RAW_W-1:0]  s_accel_raw_y,
    input  logic signed [imu_tc_pkg::RAW_W-1:0]  s_accel_raw_z,

    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic signed [imu_tc_pkg::OUT_W-1:0]  m_gyro_rate_x,
    input  logic signed [imu_tc_pkg::OUT_W-1:0]  m_gyro_rate_y,
    input  logic signed [imu_tc_pkg::OUT_W-1:0]  m_gyro_rate_z,
    input  logic signed [imu_tc_pkg::OUT_W-1:0]  m_accel_g_x,
    input  logic signed [imu_tc_pkg::OUT_W-1:0]  m_accel_g_y,
    input  logic signed [imu_tc_pkg::OUT_W-1:0]  m_accel_g_z,

    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [2:0]                           cfg_index,
    input  logic [imu_tc_pkg::COEF_W-1:0]        cfg_data,

    output int                                   fail_count,
    output int                                   outstanding
);

    localparam int     NUM_REGS = 6;
    localparam longint OUT_HI   = (longint'(1) <<< (imu_tc_pkg::OUT_W - 1)) - 1;
    localparam longint OUT_LO   = -(longint'(1) <<< (imu_tc_pkg::OUT_W - 1));

    logic [imu_tc_pkg::COEF_W-1:0] coef [NUM_REGS];
    imu_tc_pkg::out_item_t         predicted_outputs [$];
    int                            errors = 0;

    // Gain factor is Q40, effective gain in units of 2^-40; every shift floors.
    function automatic logic signed [imu_tc_pkg::OUT_W-1:0] compensate_axis(
        input logic signed [imu_tc_pkg::RAW_W-1:0] raw,
        input logic signed [imu_tc_pkg::RAW_W-1:0] temp,
        input logic [imu_tc_pkg::COEF_W-1:0]       base,
        input logic [imu_tc_pkg::COEF_W-1:0]       gain_tc,
        input logic [imu_tc_pkg::COEF_W-1:0]       offset_tc
    );
        longint raw_l, temp_l, base_l, gain_tc_l, offset_tc_l;
        longint factor, gain, acc, q;
        raw_l       = raw;
        temp_l      = temp;
        base_l      = base;
        gain_tc_l   = gain_tc;
        offset_tc_l = offset_tc;
        factor = (longint'(1) <<< imu_tc_pkg::ONE_SHIFT) + gain_tc_l * temp_l;
        gain   = (base_l * factor) >>> imu_tc_pkg::GAIN_LSB;
        acc    = raw_l * gain - offset_tc_l * temp_l;
        q      = acc >>> imu_tc_pkg::FRAC_DROP;
        if (q > OUT_HI) begin
            q = OUT_HI;
        end
        if (q < OUT_LO) begin
            q = OUT_LO;
        end
        return q[imu_tc_pkg::OUT_W-1:0];
    endfunction

    function automatic imu_tc_pkg::out_item_t compensate_sample();
        imu_tc_pkg::out_item_t r;
        r.gyro_rate_x = compensate_axis(s_gyro_raw_x, s_temp_raw,
                                        coef[imu_tc_pkg::REG_GYRO_BASE_GAIN],
                                        coef[imu_tc_pkg::REG_GYRO_GAIN_TC],
                                        coef[imu_tc_pkg::REG_GYRO_OFFSET_TC]);
        r.gyro_rate_y = compensate_axis(s_gyro_raw_y, s_temp_raw,
                                        coef[imu_tc_pkg::REG_GYRO_BASE_GAIN],
                                        coef[imu_tc_pkg::REG_GYRO_GAIN_TC],
                                        coef[imu_tc_pkg::REG_GYRO_OFFSET_TC]);
        r.gyro_rate_z = compensate_axis(s_gyro_raw_z, s_temp_raw,
                                        coef[imu_tc_pkg::REG_GYRO_BASE_GAIN],
                                        coef[imu_tc_pkg::REG_GYRO_GAIN_TC],
                                        coef[imu_tc_pkg::REG_GYRO_OFFSET_TC]);
        r.accel_g_x = compensate_axis(s_accel_raw_x, s_temp_raw,
                                      coef[imu_tc_pkg::REG_ACCEL_BASE_GAIN],
                                      coef[imu_tc_pkg::REG_ACCEL_GAIN_TC],
                                      coef[imu_tc_pkg::REG_ACCEL_OFFSET_TC]);
        r.accel_g_y = compensate_axis(s_accel_raw_y, s_temp_raw,
                                      coef[imu_tc_pkg::REG_ACCEL_BASE_GAIN],
                                      coef[imu_tc_pkg::REG_ACCEL_GAIN_TC],
                                      coef[imu_tc_pkg::REG_ACCEL_OFFSET_TC]);
        r.accel_g_z = compensate_axis(s_accel_raw_z, s_temp_raw,
                                      coef[imu_tc_pkg::REG_ACCEL_BASE_GAIN],
                                      coef[imu_tc_pkg::REG_ACCEL_GAIN_TC],
                                      coef[imu_tc_pkg::REG_ACCEL_OFFSET_TC]);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_axis(input string name,
                              input logic signed [imu_tc_pkg::OUT_W-1:0] got,
                              input logic signed [imu_tc_pkg::OUT_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    always @(posedge aclk) begin : track
        imu_tc_pkg::out_item_t want;
        if (!aresetn) begin
            coef[imu_tc_pkg::REG_GYRO_BASE_GAIN]  = imu_tc_pkg::RST_GYRO_BASE_GAIN;
            coef[imu_tc_pkg::REG_ACCEL_BASE_GAIN] = imu_tc_pkg::RST_ACCEL_BASE_GAIN;
            coef[imu_tc_pkg::REG_GYRO_GAIN_TC]    = imu_tc_pkg::RST_GYRO_GAIN_TC;
            coef[imu_tc_pkg::REG_ACCEL_GAIN_TC]   = imu_tc_pkg::RST_ACCEL_GAIN_TC;
            coef[imu_tc_pkg::REG_GYRO_OFFSET_TC]  = imu_tc_pkg::RST_GYRO_OFFSET_TC;
            coef[imu_tc_pkg::REG_ACCEL_OFFSET_TC] = imu_tc_pkg::RST_ACCEL_OFFSET_TC;
            predicted_outputs.delete();
        end else begin
            // drop writes to indexes past the register list
            if (cfg_valid && cfg_ready && cfg_index <= imu_tc_pkg::REG_ACCEL_OFFSET_TC) begin
                coef[cfg_index] = cfg_data;
            end
            if (s_valid && s_ready) begin
                predicted_outputs.push_back(compensate_sample());
            end
            if (m_valid && m_ready) begin
                if (predicted_outputs.size() == 0) begin
                    report_mismatch("result transaction with no sample outstanding");
                end else begin
                    want = predicted_outputs.pop_front();
                    check_axis("gyro_rate_x", m_gyro_rate_x, want.gyro_rate_x);
                    check_axis("gyro_rate_y", m_gyro_rate_y, want.gyro_rate_y);
                    check_axis("gyro_rate_z", m_gyro_rate_z, want.gyro_rate_z);
                    check_axis("accel_g_x", m_accel_g_x, want.accel_g_x);
                    check_axis("accel_g_y", m_accel_g_y, want.accel_g_y);
                    check_axis("accel_g_z", m_accel_g_z, want.accel_g_z);
                end
            end
        end
        outstanding <= predicted_outputs.size();
        fail_count  <= errors;
    end

endmodule

FILE: tb/sv/imu_sample_temp_compensation_tb.sv
// Testbench top for imu_sample_temp_compensation: clock, reset, sample and
// register-write stimulus, result backpressure and the verdict.
// Depends on imu_tc_pkg, imu_sample_temp_compensation and imu_sample_temp_compensation_checker.
module imu_sample_temp_compensation_tb;

    localparam int MAX_GAP        = 18;
    localparam int IDLE_LIMIT     = 2000;
    localparam int RX_HOLD_CYCLES = 240;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_SAMPLES  = 185;
    localparam int DRAIN_CYCLES   = 4 * imu_tc_pkg::PIPE_LAT;

    localparam logic [2:0]                          CFG_SPARE_A = 3'd6;
    localparam logic [2:0]                          CFG_SPARE_B = 3'd7;
    localparam logic [imu_tc_pkg::COEF_W-1:0]       COEF_MAX    = '1;
    localparam logic signed [imu_tc_pkg::RAW_W-1:0] RAW_MAX     =
        {1'b0, {(imu_tc_pkg::RAW_W-1){1'b1}}};
    localparam logic signed [imu_tc_pkg::RAW_W-1:0] RAW_MIN     =
        {1'b1, {(imu_tc_pkg::RAW_W-1){1'b0}}};
    localparam logic signed [imu_tc_pkg::RAW_W-1:0] RAW_ONE_C   = 16'sd256;

    typedef enum {IDLE_NONE, IDLE_SPARSE, IDLE_RANDOM} idle_mode_t;

    typedef struct packed {
        logic signed [imu_tc_pkg::RAW_W-1:0] temp_raw;
        logic signed [imu_tc_pkg::RAW_W-1:0] gyro_raw_x;
        logic signed [imu_tc_pkg::RAW_W-1:0] gyro_raw_y;
        logic signed [imu_tc_pkg::RAW_W-1:0] gyro_raw_z;
        logic signed [imu_tc_pkg::RAW_W-1:0] accel_raw_x;
        logic signed [imu_tc_pkg::RAW_W-1:0] accel_raw_y;
        logic signed [imu_tc_pkg::RAW_W-1:0] accel_raw_z;
    } raw_sample_t;

    typedef struct packed {
        logic [imu_tc_pkg::COEF_W-1:0] gyro_base_gain;
        logic [imu_tc_pkg::COEF_W-1:0] accel_base_gain;
        logic [imu_tc_pkg::COEF_W-1:0] gyro_gain_tc;
        logic [imu_tc_pkg::COEF_W-1:0] accel_gain_tc;
        logic [imu_tc_pkg::COEF_W-1:0] gyro_offset_tc;
        logic [imu_tc_pkg::COEF_W-1:0] accel_offset_tc;
    } coef_set_t;

    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic signed [imu_tc_pkg::RAW_W-1:0] s_temp_raw;
    logic signed [imu_tc_pkg::RAW_W-1:0] s_gyro_raw_x;
    logic signed [imu_tc_pkg::RAW_W-1:0] s_gyro_raw_y;
    logic signed [imu_tc_pkg::RAW_W-1:0] s_gyro_raw_z;
    logic signed [imu_tc_pkg::RAW_W-1:0] s_accel_raw_x;
    logic signed [imu_tc_pkg::RAW_W-1:0] s_accel_raw_y;
    logic signed [imu_tc_pkg::RAW_W-1:0] s_accel_raw_z;
    logic                                m_valid;
    logic                                m_ready;
    logic signed [imu_tc_pkg::OUT_W-1:0] m_gyro_rate_x;
    logic signed [imu_tc_pkg::OUT_W-1:0] m_gyro_rate_y;
    logic signed [imu_tc_pkg::OUT_W-1:0] m_gyro_rate_z;
    logic signed [imu_tc_pkg::OUT_W-1:0] m_accel_g_x;
    logic signed [imu_tc_pkg::OUT_W-1:0] m_accel_g_y;
    logic signed [imu_tc_pkg::OUT_W-1:0] m_accel_g_z;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [2:0]                          cfg_index;
    logic [imu_tc_pkg::COEF_W-1:0]       cfg_data;

    int         fail_count;
    int         outstanding;
    int         idle_cycles = 0;
    int         rx_stall_req = 0;
    idle_mode_t tx_mode = IDLE_NONE;
    idle_mode_t rx_mode = IDLE_NONE;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    imu_sample_temp_compensation i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_temp_raw    (s_temp_raw),
        .s_gyro_raw_x  (s_gyro_raw_x),
        .s_gyro_raw_y  (s_gyro_raw_y),
        .s_gyro_raw_z  (s_gyro_raw_z),
        .s_accel_raw_x (s_accel_raw_x),
        .s_accel_raw_y (s_accel_raw_y),
        .s_accel_raw_z (s_accel_raw_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_gyro_rate_x (m_gyro_rate_x),
        .m_gyro_rate_y (m_gyro_rate_y),
        .m_gyro_rate_z (m_gyro_rate_z),
        .m_accel_g_x   (m_accel_g_x),
        .m_accel_g_y   (m_accel_g_y),
        .m_accel_g_z   (m_accel_g_z),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    imu_sample_temp_compensation_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_temp_raw    (s_temp_raw),
        .s_gyro_raw_x  (s_gyro_raw_x),
        .s_gyro_raw_y  (s_gyro_raw_y),
        .s_gyro_raw_z  (s_gyro_raw_z),
        .s_accel_raw_x (s_accel_raw_x),
        .s_accel_raw_y (s_accel_raw_y),
        .s_accel_raw_z (s_accel_raw_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_gyro_rate_x (m_gyro_rate_x),
        .m_gyro_rate_y (m_gyro_rate_y),
        .m_gyro_rate_z (m_gyro_rate_z),
        .m_accel_g_x   (m_accel_g_x),
        .m_accel_g_y   (m_accel_g_y),
        .m_accel_g_z   (m_accel_g_z),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    function automatic int draw_gap(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:   return 0;
            IDLE_SPARSE: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAX_GAP) : 0;
            default:     return $urandom_range(0, MAX_GAP);
        endcase
    endfunction

    function automatic idle_mode_t pick_mode();
        return idle_mode_t'($urandom_range(0, 2));
    endfunction

    function automatic logic signed [imu_tc_pkg::RAW_W-1:0] rand_raw();
        logic signed [imu_tc_pkg::RAW_W-1:0] v;
        logic [31:0]                         w;
        w = $urandom();
        case ($urandom_range(0, 9))
            0:       v = RAW_MIN;
            1:       v = RAW_MAX;
            2:       v = '0;
            3: begin
                w = $urandom_range(0, 511) - 256;
                v = w[imu_tc_pkg::RAW_W-1:0];
            end
            default: v = w[imu_tc_pkg::RAW_W-1:0];
        endcase
        return v;
    endfunction

    function automatic raw_sample_t rand_sample();
        raw_sample_t smp;
        smp.temp_raw    = rand_raw();
        smp.gyro_raw_x  = rand_raw();
        smp.gyro_raw_y  = rand_raw();
        smp.gyro_raw_z  = rand_raw();
        smp.accel_raw_x = rand_raw();
        smp.accel_raw_y = rand_raw();
        smp.accel_raw_z = rand_raw();
        return smp;
    endfunction

    function automatic raw_sample_t uniform_sample(
        input logic signed [imu_tc_pkg::RAW_W-1:0] temp,
        input logic signed [imu_tc_pkg::RAW_W-1:0] gyro,
        input logic signed [imu_tc_pkg::RAW_W-1:0] accel
    );
        return '{temp, gyro, gyro, gyro, accel, accel, accel};
    endfunction

    function automatic logic [imu_tc_pkg::COEF_W-1:0] rand_coef();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return COEF_MAX;
            2:       return {{(imu_tc_pkg::COEF_W-8){1'b0}}, w[7:0]};
            default: return w[imu_tc_pkg::COEF_W-1:0];
        endcase
    endfunction

    function automatic coef_set_t rand_coef_set();
        return '{rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef()};
    endfunction

    task automatic write_reg(input logic [2:0] idx,
                             input logic [imu_tc_pkg::COEF_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Call only with nothing outstanding; spare indexes go last to expose aliasing.
    task automatic load_coefs(input coef_set_t cs);
        write_reg(imu_tc_pkg::REG_GYRO_BASE_GAIN, cs.gyro_base_gain);
        write_reg(imu_tc_pkg::REG_ACCEL_BASE_GAIN, cs.accel_base_gain);
        write_reg(imu_tc_pkg::REG_GYRO_GAIN_TC, cs.gyro_gain_tc);
        write_reg(imu_tc_pkg::REG_ACCEL_GAIN_TC, cs.accel_gain_tc);
        write_reg(imu_tc_pkg::REG_GYRO_OFFSET_TC, cs.gyro_offset_tc);
        write_reg(imu_tc_pkg::REG_ACCEL_OFFSET_TC, cs.accel_offset_tc);
        write_reg(CFG_SPARE_A, rand_coef());
        write_reg(CFG_SPARE_B, rand_coef());
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input raw_sample_t smp);
        int gap;
        gap = draw_gap(tx_mode);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_temp_raw    <= smp.temp_raw;
        s_gyro_raw_x  <= smp.gyro_raw_x;
        s_gyro_raw_y  <= smp.gyro_raw_y;
        s_gyro_raw_z  <= smp.gyro_raw_z;
        s_accel_raw_x <= smp.accel_raw_x;
        s_accel_raw_y <= smp.accel_raw_y;
        s_accel_raw_z <= smp.accel_raw_z;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold the input idle until every predicted result has been taken.
    task automatic drain_samples();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (imu_tc_pkg::PIPE_LAT + 2) @(posedge aclk);
    endtask

    initial begin : receiver
        int hold_left;
        int wait_left;
        int stall_seen;
        hold_left  = 0;
        wait_left  = 0;
        stall_seen = 0;
        m_ready    = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_stall_req != stall_seen) begin
                stall_seen = rx_stall_req;
                hold_left  = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (wait_left > 0) begin
                wait_left--;
                m_ready <= 1'b0;
            end else if (m_valid && m_ready) begin
                wait_left = draw_gap(rx_mode);
                m_ready <= (wait_left == 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("imu_sample_temp_compensation test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        coef_set_t cs;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_temp_raw    = '0;
        s_gyro_raw_x  = '0;
        s_gyro_raw_y  = '0;
        s_gyro_raw_z  = '0;
        s_accel_raw_x = '0;
        s_accel_raw_y = '0;
        s_accel_raw_z = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // zero base gain right after reset: the very first sample sees only the bias term
        tx_mode = IDLE_SPARSE;
        rx_mode = IDLE_SPARSE;
        load_coefs('{'0, '0, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX});
        send_sample(uniform_sample(RAW_MAX, RAW_MAX, RAW_MAX));
        send_sample(uniform_sample(RAW_MIN, RAW_MIN, RAW_MAX));
        send_sample(uniform_sample('0, RAW_MAX, RAW_MIN));
        drain_samples();

        load_coefs('{imu_tc_pkg::RST_GYRO_BASE_GAIN, imu_tc_pkg::RST_ACCEL_BASE_GAIN,
                     imu_tc_pkg::RST_GYRO_GAIN_TC, imu_tc_pkg::RST_ACCEL_GAIN_TC,
                     imu_tc_pkg::RST_GYRO_OFFSET_TC, imu_tc_pkg::RST_ACCEL_OFFSET_TC});
        send_sample(uniform_sample('0, '0, '0));
        send_sample(uniform_sample(RAW_MAX, RAW_MAX, RAW_MAX));
        send_sample(uniform_sample(RAW_MAX, RAW_MIN, RAW_MIN));
        send_sample(uniform_sample(RAW_MIN, RAW_MAX, RAW_MAX));
        send_sample(uniform_sample(RAW_MIN, RAW_MIN, RAW_MIN));
        send_sample('{'0, RAW_MAX, RAW_MIN, '0, '1, 16'sd1, RAW_MAX});
        send_sample('{-RAW_ONE_C, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6});
        send_sample(uniform_sample(RAW_ONE_C, '1, '1));
        drain_samples();

        // largest coefficients push some of the extreme samples into saturation
        tx_mode = IDLE_NONE;
        rx_mode = IDLE_NONE;
        load_coefs('{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX});
        send_sample(uniform_sample(RAW_MAX, RAW_MAX, RAW_MAX));
        send_sample(uniform_sample(RAW_MAX, RAW_MIN, RAW_MIN));
        send_sample(uniform_sample(RAW_MIN, RAW_MAX, RAW_MIN));
        send_sample(uniform_sample(RAW_MIN, RAW_MIN, RAW_MAX));
        send_sample(uniform_sample('0, RAW_MAX, RAW_MIN));
        send_sample(uniform_sample(RAW_MIN, '0, '0));
        drain_samples();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       cs = '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX};
                1:       cs = '0;
                2:       cs = '{imu_tc_pkg::RST_GYRO_BASE_GAIN,
                                imu_tc_pkg::RST_ACCEL_BASE_GAIN,
                                imu_tc_pkg::RST_GYRO_GAIN_TC,
                                imu_tc_pkg::RST_ACCEL_GAIN_TC,
                                imu_tc_pkg::RST_GYRO_OFFSET_TC,
                                imu_tc_pkg::RST_ACCEL_OFFSET_TC};
                default: cs = rand_coef_set();
            endcase
            load_coefs(cs);
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                if (phase == 3) begin
                    // keep offering back to back while the result side stalls
                    tx_mode = IDLE_NONE;
                    rx_mode = IDLE_RANDOM;
                    if (n == 20) begin
                        rx_stall_req++;
                    end
                end else if (n % 40 == 0) begin
                    tx_mode = pick_mode();
                    rx_mode = pick_mode();
                end
                send_sample(rand_sample());
            end
            drain_samples();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("imu_sample_temp_compensation test passed");
        end else begin
            $display("imu_sample_temp_compensation test failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/imu_tc_pkg.sv
src/imu_tc_gain.sv
src/imu_tc_lane.sv
src/imu_tc_fifo.sv
src/imu_sample_temp_compensation.sv
tb/sv/imu_sample_temp_compensation_checker.sv
tb/sv/imu_sample_temp_compensation_tb.sv
